// ----- sv/banked_memory_mapper_core_defines.svh -----
// ----------------------------------------------------------------------------
// banked_memory_mapper_core_defines.svh
// Assertion macros used by the mapper checker.
// ----------------------------------------------------------------------------
`ifndef BANKED_MEMORY_MAPPER_CORE_DEFINES_SVH
`define BANKED_MEMORY_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mapper check failed");

// next-cycle implication, disabled in reset
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mapper check failed");

`endif

// ----- sv/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg
// Types and codes for the banked memory mapper.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam logic [1:0] MODE_FLAT   = 2'd0;
    localparam logic [1:0] MODE_BANKED = 2'd1;
    localparam logic [1:0] MODE_MMU    = 2'd2;

    localparam logic [1:0] CFG_MAP_MODE      = 2'd0;
    localparam logic [1:0] CFG_DISK_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_VIDEO_PRESENT = 2'd2;

    localparam logic [7:0] IO_PAGE = 8'hFE;

    typedef enum logic [2:0] {
        DEV_NONE   = 3'd0,
        DEV_DISK   = 3'd1,
        DEV_VIDEO  = 3'd2,
        DEV_SERIAL = 3'd3,
        DEV_MAPPER = 3'd4
    } io_dev_t;

    typedef struct packed {
        logic       video_present;
        logic       disk_present;
        logic [1:0] map_mode;
    } map_cfg_t;

    typedef struct packed {
        logic [3:0][5:0] bank_regs;
        logic            bank_on;
        logic [7:0]      mmu_byte;
    } map_state_t;

    localparam map_state_t STATE_RESET = '{
        bank_regs: {6'd33, 6'd32, 6'd1, 6'd0},
        bank_on:   1'b1,
        mmu_byte:  8'd0
    };

    // packed lowest field last: kind in bit 0
    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] address;
        logic        kind;
    } bus_req_t;

    typedef struct packed {
        logic [3:0]  io_offset;
        io_dev_t     io_device;
        logic        mem_write;
        logic        mem_select;
        logic [19:0] phys_address;
    } map_result_t;

endpackage

// ----- sv/bmm_xlate.sv -----
// ----------------------------------------------------------------------------
// bmm_xlate
// Port decode, mapper register update and address translation for one request.
// ----------------------------------------------------------------------------
module bmm_xlate (
    input  bmm_pkg::map_cfg_t    cfg,
    input  bmm_pkg::map_state_t  state,
    input  bmm_pkg::bus_req_t    req,
    output bmm_pkg::map_state_t  state_next,
    output bmm_pkg::map_result_t result
);

    logic [7:0]          port;
    logic                io_page;
    logic                wr;
    bmm_pkg::map_state_t st;
    bmm_pkg::io_dev_t    dev;
    logic [3:0]          off;
    logic [7:0]          mmu_sh;
    logic [3:0]          page;
    logic [5:0]          bank;
    logic [19:0]         phys;
    logic                storable;
    logic                sel;

    // port decode; mapper writes update the state before translation
    always_comb
    begin
        port    = req.address[7:0];
        io_page = (req.address[15:8] == bmm_pkg::IO_PAGE);
        wr      = req.kind;
        st      = state;
        dev     = bmm_pkg::DEV_NONE;
        off     = 4'd0;
        if (io_page)
        begin
            if (wr && port == 8'hFF && cfg.map_mode == bmm_pkg::MODE_MMU)
            begin
                st.mmu_byte = req.write_data;
                dev         = bmm_pkg::DEV_MAPPER;
                off         = port[3:0];
            end
            else if (cfg.disk_present && port[7:3] == 5'b00010)
            begin
                dev = bmm_pkg::DEV_DISK;
                off = {1'b0, port[2:0]};
            end
            else if (wr && cfg.map_mode == bmm_pkg::MODE_BANKED && port[7:2] == 6'b011110)
            begin
                st.bank_regs[port[1:0]] = req.write_data[5:0];
                dev                     = bmm_pkg::DEV_MAPPER;
                off                     = port[3:0];
            end
            else if (wr && cfg.map_mode == bmm_pkg::MODE_BANKED && port[7:2] == 6'b011111)
            begin
                st.bank_on = req.write_data[0];
                dev        = bmm_pkg::DEV_MAPPER;
                off        = port[3:0];
            end
            else if (cfg.video_present && port[7:1] == 7'b1001100)
            begin
                dev = bmm_pkg::DEV_VIDEO;
                off = {3'b000, port[0]};
            end
            else if (port[7:4] == 4'hC)
            begin
                dev = bmm_pkg::DEV_SERIAL;
                off = port[3:0];
            end
        end
    end

    // translation against the updated state
    always_comb
    begin
        mmu_sh   = (req.address < 16'hE000) ? {1'b0, st.mmu_byte[7:1]} : st.mmu_byte;
        page     = {mmu_sh[0], mmu_sh[2], mmu_sh[4], mmu_sh[6]};
        bank     = st.bank_regs[req.address[15:14]];
        phys     = {4'd0, req.address};
        storable = 1'b0;
        case (cfg.map_mode)
            bmm_pkg::MODE_MMU:
            begin
                phys     = {page, req.address};
                storable = page[3];
            end
            bmm_pkg::MODE_BANKED:
            begin
                if (st.bank_on)
                begin
                    phys     = {bank, req.address[13:0]};
                    storable = bank[5];
                end
            end
            default:
            begin
                // flat, and the undefined mode: ROM below 8K
                storable = |req.address[15:13];
            end
        endcase
    end

    assign sel        = !(io_page && !wr);
    assign state_next = st;

    assign result.phys_address = sel ? phys : 20'd0;
    assign result.mem_select   = sel;
    assign result.mem_write    = sel && wr && storable;
    assign result.io_device    = dev;
    assign result.io_offset    = off;

endmodule

// ----- sv/banked_memory_mapper_core.sv -----
// ----------------------------------------------------------------------------
// banked_memory_mapper_core
// CPU bus access mapper: logical to physical address, store and I/O select.
// ----------------------------------------------------------------------------
// Takes one bus request per clock unless the output stalls, and returns
// one result per request, which passes the request register and then the
// result register. Decode and translation sit between those two registers.
// A write to a mapper port updates the bank or MMU registers as it leaves the
// request register, so the very next request already sees the new mapping.
// Configuration writes (map_mode, disk_present, video_present) are meant to
// land while no request is in flight.
module banked_memory_mapper_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // address[15:0], write_data[23:16]
    input  logic        s_tuser,    // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // phys_address[19:0], mem_select[20],
                                    // mem_write[21], io_device[24:22],
                                    // io_offset[28:25]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    logic                  req_valid_reg;
    bmm_pkg::bus_req_t     req_reg;
    logic                  out_valid_reg;
    bmm_pkg::map_result_t  out_reg;
    bmm_pkg::map_state_t   state_reg;
    bmm_pkg::map_state_t   state_next;
    bmm_pkg::map_cfg_t     cfg_reg;
    bmm_pkg::map_result_t  result;
    logic                  advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !req_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    bmm_xlate u_xlate (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (req_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= bmm_pkg::STATE_RESET;
        end
        else
        begin
            if (s_tready)
                req_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= req_valid_reg;
            if (advance && req_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            req_reg <= bmm_pkg::bus_req_t'({s_tdata, s_tuser});
        if (advance && req_valid_reg)
            out_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bmm_pkg::CFG_MAP_MODE:      cfg_reg.map_mode      <= cfg_data;
                bmm_pkg::CFG_DISK_PRESENT:  cfg_reg.disk_present  <= cfg_data[0];
                bmm_pkg::CFG_VIDEO_PRESENT: cfg_reg.video_present <= cfg_data[0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- sv/bmm_checker.sv -----
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks for the banked memory mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "banked_memory_mapper_core_defines.svh"

module bmm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `BMM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input side only stalls when a finished result is waiting
    `BMM_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // I/O page read: store idle, no mapper side effect
    `BMM_ASSERT_NOW(a_nosel_quiet, clk, rst_n, m_tvalid && !m_tdata[20], m_tdata[21:0] == 22'd0 && m_tdata[24:22] != bmm_pkg::DEV_MAPPER)

    `BMM_ASSERT_NOW(a_dev_code, clk, rst_n, m_tvalid, m_tdata[24:22] <= bmm_pkg::DEV_MAPPER && (m_tdata[24:22] != bmm_pkg::DEV_NONE || m_tdata[28:25] == 4'd0))

endmodule

bind banked_memory_mapper_core bmm_checker u_bmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
